// File: sv/qte_pkg.sv
package qte_pkg;

   localparam int QW         = 32;  // quaternion component width
   localparam int PW         = 64;  // product / operand width (Q60 products, Q56 operands)
   localparam int CW         = 66;  // CORDIC x/y datapath width
   localparam int ANGW       = 34;  // Q30 radian angle width
   localparam int S30W       = 32;  // pitch sine in Q30
   localparam int RADW       = 61;  // sqrt radicand width
   localparam int ROOTW      = 31;  // sqrt root width
   localparam int REMW       = 63;  // sqrt remainder / trial width
   localparam int SCALEW     = 14;
   localparam int PRODW      = ANGW + SCALEW;
   localparam int VW         = PRODW - 29;
   localparam int ROLLW      = 16;
   localparam int PITCHW     = 15;
   localparam int QUEUE_DEPTH = 2;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam logic signed [PW-1:0]     ONE_Q56    = 64'sh0100_0000_0000_0000;
   localparam logic signed [PW-1:0]     ONE_Q60    = 64'sh1000_0000_0000_0000;
   localparam logic signed [ANGW-1:0]   HALF_PI    = ANGW'(1686629713);
   localparam logic signed [SCALEW-1:0] DEG_SCALE  = 14'sd5730;
   localparam logic signed [PRODW:0]    ROUND_HALF = (PRODW+1)'(64'd536870912);
   localparam logic signed [15:0]       ROLL_LIM   = 16'sd18002;
   localparam logic signed [15:0]       PITCH_LIM  = 16'sd9001;

   typedef struct packed {
      logic signed [PW-1:0]   roll_y;
      logic signed [PW-1:0]   roll_x;
      logic signed [PW-1:0]   yaw_y;
      logic signed [PW-1:0]   yaw_x;
      logic signed [S30W-1:0] s30;
   } opnd_type;

   function automatic logic signed [ANGW-1:0] atan_q30(input int idx);
      logic [31:0] t;
      case (idx)
         0: t = 32'h3243F6A8;
         1: t = 32'h1DAC6705;
         2: t = 32'h0FADBAFC;
         3: t = 32'h07F56EA6;
         4: t = 32'h03FEAB76;
         5: t = 32'h01FFD55B;
         6: t = 32'h00FFFAAA;
         7: t = 32'h007FFF55;
         8: t = 32'h003FFFEA;
         9: t = 32'h001FFFFD;
         10: t = 32'h000FFFFF;
         11: t = 32'h0007FFFF;
         12: t = 32'h0003FFFF;
         13: t = 32'h0001FFFF;
         14: t = 32'h0000FFFF;
         15: t = 32'h00007FFF;
         16: t = 32'h00003FFF;
         17: t = 32'h00001FFF;
         18: t = 32'h00000FFF;
         19: t = 32'h000007FF;
         20: t = 32'h000003FF;
         21: t = 32'h000001FF;
         22: t = 32'h000000FF;
         23: t = 32'h0000007F;
         24: t = 32'h0000003F;
         25: t = 32'h0000001F;
         26: t = 32'h0000000F;
         27: t = 32'h00000007;
         28: t = 32'h00000003;
         29: t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      atan_q30 = $signed(ANGW'(t));
   endfunction

   function automatic logic signed [PW-1:0] smul32(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
      smul32 = a * b;
   endfunction

   // round half up to hundredths of a degree, then saturate
   function automatic logic signed [15:0] to_units(input logic signed [PRODW-1:0] prod,
                                                   input logic signed [15:0] lim);
      logic signed [PRODW:0] sum;
      logic signed [VW-1:0]  v;
      sum = (PRODW+1)'(prod) + ROUND_HALF;
      v = $signed(sum[PRODW:30]);
      if (v > VW'(lim)) begin
         to_units = lim;
      end else if (v < -VW'(lim)) begin
         to_units = -lim;
      end else begin
         to_units = v[15:0];
      end
   endfunction

endpackage

// File: sv/qte_front.sv
module qte_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [qte_pkg::QW-1:0] quat_w,
   input  logic signed [qte_pkg::QW-1:0] quat_x,
   input  logic signed [qte_pkg::QW-1:0] quat_y,
   input  logic signed [qte_pkg::QW-1:0] quat_z,
   output logic                         push,
   output qte_pkg::opnd_type            push_data
);

   logic                           v1_ff, v2_ff, v3_ff;
   logic signed [qte_pkg::QW-1:0]  w_ff, x_ff, y_ff, z_ff;
   logic signed [qte_pkg::PW-1:0]  ww_ff, xx_ff, yy_ff, zz_ff, wx_ff;
   logic signed [qte_pkg::PW-1:0]  wy_ff, wz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [qte_pkg::PW-1:0]  s_raw, s_cl;
   qte_pkg::opnd_type              opnd_in, opnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= quat_w;
      x_ff  <= quat_x;
      y_ff  <= quat_y;
      z_ff  <= quat_z;
      ww_ff <= qte_pkg::smul32(w_ff, w_ff);
      xx_ff <= qte_pkg::smul32(x_ff, x_ff);
      yy_ff <= qte_pkg::smul32(y_ff, y_ff);
      zz_ff <= qte_pkg::smul32(z_ff, z_ff);
      wx_ff <= qte_pkg::smul32(w_ff, x_ff);
      wy_ff <= qte_pkg::smul32(w_ff, y_ff);
      wz_ff <= qte_pkg::smul32(w_ff, z_ff);
      xy_ff <= qte_pkg::smul32(x_ff, y_ff);
      xz_ff <= qte_pkg::smul32(x_ff, z_ff);
      yz_ff <= qte_pkg::smul32(y_ff, z_ff);
      opnd_ff <= opnd_in;
   end

   // Q60 products floored to Q56
   always_comb begin
      opnd_in.roll_y = ((yz_ff >>> 4) + (wx_ff >>> 4)) <<< 1;
      opnd_in.roll_x = qte_pkg::ONE_Q56 - ((xx_ff >>> 4) <<< 1) - ((yy_ff >>> 4) <<< 1);
      opnd_in.yaw_y  = ((xy_ff >>> 4) + (wz_ff >>> 4)) <<< 1;
      opnd_in.yaw_x  = (ww_ff >>> 4) + (xx_ff >>> 4) - (yy_ff >>> 4) - (zz_ff >>> 4);
      s_raw = ((wy_ff >>> 4) - (xz_ff >>> 4)) <<< 1;
      if (s_raw > qte_pkg::ONE_Q56) begin
         s_cl = qte_pkg::ONE_Q56;
      end else if (s_raw < -qte_pkg::ONE_Q56) begin
         s_cl = -qte_pkg::ONE_Q56;
      end else begin
         s_cl = s_raw;
      end
      opnd_in.s30 = qte_pkg::S30W'(s_cl >>> 26);
   end

   assign push      = v3_ff;
   assign push_data = opnd_ff;

endmodule

// File: sv/qte_queue.sv
module qte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qte_pkg::opnd_type push_data,
   output logic              full,
   output logic              pop,
   output qte_pkg::opnd_type pop_data
);

   localparam int DEPTH = qte_pkg::QUEUE_DEPTH;
   localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW  = $clog2(DEPTH + 1);

   qte_pkg::opnd_type mem_ff [DEPTH];
   logic [PTRW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;

   assign pop      = (count_ff != '0);
   assign full     = (count_ff == CNTW'(DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // the back end drains every cycle, so the queue never holds more than one
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNTW'(1))
      else $error("queue holds more than one transaction");
   assert property (@(posedge clock) disable iff (reset) push |=> count_ff != '0)
      else $error("pushed transaction not visible");

endmodule

// File: sv/qte_isqrt.sv
module qte_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_in,
   input  logic [qte_pkg::RADW-1:0]       rad_in,
   input  logic [SIDE_W-1:0]              side_in,
   output logic                           valid_out,
   output logic [qte_pkg::ROOTW-1:0]      root_out,
   output logic [SIDE_W-1:0]              side_out
);

   localparam int ROOTW = qte_pkg::ROOTW;
   localparam int REMW  = qte_pkg::REMW;

   logic              v_ff    [ROOTW];
   logic [REMW-1:0]   rem_ff  [ROOTW];
   logic [ROOTW-1:0]  root_ff [ROOTW];
   logic [SIDE_W-1:0] side_ff [ROOTW];

   // one root bit per stage, most significant first
   for (genvar k = 0; k < ROOTW; k++) begin : g_stage
      localparam int B = ROOTW - 1 - k;
      logic              v_i;
      logic [REMW-1:0]   rem_i, trial;
      logic [ROOTW-1:0]  root_i;
      logic [SIDE_W-1:0] side_i;

      if (k == 0) begin : g_first
         assign v_i    = valid_in;
         assign rem_i  = REMW'(rad_in);
         assign root_i = '0;
         assign side_i = side_in;
      end else begin : g_next
         assign v_i    = v_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      assign trial = (REMW'(root_i) << (B + 1)) | (REMW'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         side_ff[k] <= side_i;
         if (rem_i >= trial) begin
            rem_ff[k]  <= rem_i - trial;
            root_ff[k] <= root_i | (ROOTW'(1) << B);
         end else begin
            rem_ff[k]  <= rem_i;
            root_ff[k] <= root_i;
         end
      end
   end

   assign valid_out = v_ff[ROOTW-1];
   assign root_out  = root_ff[ROOTW-1];
   assign side_out  = side_ff[ROOTW-1];

endmodule

// File: sv/qte_cordic.sv
module qte_cordic #(
   parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  logic signed [qte_pkg::PW-1:0]      y_in,
   input  logic signed [qte_pkg::PW-1:0]      x_in,
   output logic                               valid_out,
   output logic signed [qte_pkg::ANGW-1:0]    ang_out
);

   localparam int CW   = qte_pkg::CW;
   localparam int ANGW = qte_pkg::ANGW;

   logic                   v_ff  [STEPS+1];
   logic                   zf_ff [STEPS+1];
   logic signed [CW-1:0]   x_ff  [STEPS+1];
   logic signed [CW-1:0]   y_ff  [STEPS+1];
   logic signed [ANGW-1:0] z_ff  [STEPS+1];
   logic signed [CW-1:0]   xe, ye;

   assign xe = CW'(x_in);
   assign ye = CW'(y_in);

   // fold the left half plane into the right one
   always_ff @(posedge clock) begin
      zf_ff[0] <= (x_in == '0) && (y_in == '0);
      if (xe[CW-1] && !ye[CW-1]) begin
         x_ff[0] <= ye;
         y_ff[0] <= -xe;
         z_ff[0] <= qte_pkg::HALF_PI;
      end else if (xe[CW-1]) begin
         x_ff[0] <= -ye;
         y_ff[0] <= xe;
         z_ff[0] <= -qte_pkg::HALF_PI;
      end else begin
         x_ff[0] <= xe;
         y_ff[0] <= ye;
         z_ff[0] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= valid_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [CW-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         zf_ff[i+1] <= zf_ff[i];
         if (!y_ff[i][CW-1]) begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + qte_pkg::atan_q30(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - qte_pkg::atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end
   end

   assign valid_out = v_ff[STEPS];
   assign ang_out   = zf_ff[STEPS] ? '0 : z_ff[STEPS];

endmodule

// File: sv/qte_back.sv
module qte_back #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pop,
   input  qte_pkg::opnd_type                     pop_data,
   output logic                                  rsp_valid,
   output logic signed [qte_pkg::ROLLW-1:0]      rsp_roll_angle,
   output logic signed [qte_pkg::PITCHW-1:0]     rsp_pitch_angle,
   output logic signed [qte_pkg::ROLLW-1:0]      rsp_yaw_angle
);

   localparam int SIDE_W = $bits(qte_pkg::opnd_type);

   logic                                 v1_ff, v2_ff, vm_ff, vo_ff;
   qte_pkg::opnd_type                    op1_ff, op2_ff, op_sq;
   logic signed [qte_pkg::PW-1:0]        sq_ff;
   logic [qte_pkg::RADW-1:0]             rad_ff;
   logic                                 sq_valid;
   logic [qte_pkg::ROOTW-1:0]            root;
   logic [SIDE_W-1:0]                    side;
   logic                                 vr, vp, vy;
   logic signed [qte_pkg::ANGW-1:0]      ang_roll, ang_pitch, ang_yaw;
   logic signed [qte_pkg::PRODW-1:0]     m_roll_ff, m_pitch_ff, m_yaw_ff;
   logic signed [15:0]                   u_roll, u_pitch, u_yaw;
   logic signed [qte_pkg::ROLLW-1:0]     roll_ff, yaw_ff;
   logic signed [qte_pkg::PITCHW-1:0]    pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vm_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         vm_ff <= vr;
         vo_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff <= pop_data;
      sq_ff  <= pop_data.s30 * pop_data.s30;
      op2_ff <= op1_ff;
      rad_ff <= qte_pkg::RADW'(qte_pkg::ONE_Q60 - sq_ff);
   end

   // cosine of pitch; roll and yaw operands ride along to stay aligned
   qte_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v2_ff),
      .rad_in    (rad_ff),
      .side_in   (op2_ff),
      .valid_out (sq_valid),
      .root_out  (root),
      .side_out  (side)
   );

   assign op_sq = qte_pkg::opnd_type'(side);

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sq_valid),
      .y_in      (op_sq.roll_y),
      .x_in      (op_sq.roll_x),
      .valid_out (vr),
      .ang_out   (ang_roll)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sq_valid),
      .y_in      (qte_pkg::PW'(op_sq.s30)),
      .x_in      ($signed(qte_pkg::PW'(root))),
      .valid_out (vp),
      .ang_out   (ang_pitch)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sq_valid),
      .y_in      (op_sq.yaw_y),
      .x_in      (op_sq.yaw_x),
      .valid_out (vy),
      .ang_out   (ang_yaw)
   );

   always_ff @(posedge clock) begin
      m_roll_ff  <= ang_roll * qte_pkg::DEG_SCALE;
      m_pitch_ff <= ang_pitch * qte_pkg::DEG_SCALE;
      m_yaw_ff   <= ang_yaw * qte_pkg::DEG_SCALE;
      roll_ff    <= u_roll;
      pitch_ff   <= u_pitch[qte_pkg::PITCHW-1:0];
      yaw_ff     <= u_yaw;
   end

   assign u_roll  = qte_pkg::to_units(m_roll_ff, qte_pkg::ROLL_LIM);
   assign u_pitch = qte_pkg::to_units(m_pitch_ff, qte_pkg::PITCH_LIM);
   assign u_yaw   = qte_pkg::to_units(m_yaw_ff, qte_pkg::ROLL_LIM);

   assign rsp_valid       = vo_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

   assert property (@(posedge clock) disable iff (reset) vr == vp && vr == vy)
      else $error("angle lanes out of step");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> (rsp_pitch_angle <= 15'sd9001 && rsp_pitch_angle >= -15'sd9001))
      else $error("pitch out of range");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> (rsp_roll_angle <= 16'sd18002 && rsp_roll_angle >= -16'sd18002))
      else $error("roll out of range");

endmodule

// File: sv/quaternion_to_euler_angles.sv
// Quaternion to Z-Y-X Euler angles.
// Input: raise start with req_quat_w/x/y/z (signed Q30, 1.0 = 2^30); the
// transaction is taken at a rising edge where start is high and busy is low.
// Output: rsp_valid is high for one cycle with rsp_roll_angle, rsp_pitch_angle
// and rsp_yaw_angle in hundredths of a degree (one radian = 5730 units).
// Throughput: one transaction per cycle. The front end forms the ten
// component products and the atan2 operands, a two-entry queue hands them to
// the back end, which runs a 31-stage square root for the pitch cosine and
// three pipelined CORDIC units, one stage per micro-rotation.
// busy only rises if the queue fills; with the back end draining every cycle
// it stays low. The receiver cannot stall: each result is there for one
// cycle only. Synchronous reset flushes every transaction in flight.
module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [qte_pkg::QW-1:0]         req_quat_w,
   input  logic signed [qte_pkg::QW-1:0]         req_quat_x,
   input  logic signed [qte_pkg::QW-1:0]         req_quat_y,
   input  logic signed [qte_pkg::QW-1:0]         req_quat_z,
   output logic                                  rsp_valid,
   output logic signed [qte_pkg::ROLLW-1:0]      rsp_roll_angle,
   output logic signed [qte_pkg::PITCHW-1:0]     rsp_pitch_angle,
   output logic signed [qte_pkg::ROLLW-1:0]      rsp_yaw_angle
);

   logic              accept, push, pop, full;
   qte_pkg::opnd_type push_data, pop_data;

   assign accept = start && !busy;
   assign busy   = full;

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .push      (push),
      .push_data (push_data)
   );

   qte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data)
   );

   qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop             (pop),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle)
   );

endmodule

// File: tb/quaternion_to_euler_angles_chk.sv
module quaternion_to_euler_angles_chk #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic signed [qte_pkg::QW-1:0]         req_quat_w,
   input  logic signed [qte_pkg::QW-1:0]         req_quat_x,
   input  logic signed [qte_pkg::QW-1:0]         req_quat_y,
   input  logic signed [qte_pkg::QW-1:0]         req_quat_z,
   input  logic                                  rsp_valid,
   input  logic signed [qte_pkg::ROLLW-1:0]      rsp_roll_angle,
   input  logic signed [qte_pkg::PITCHW-1:0]     rsp_pitch_angle,
   input  logic signed [qte_pkg::ROLLW-1:0]      rsp_yaw_angle,
   output int                                    fail_count,
   output int                                    angles_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [qte_pkg::ROLLW-1:0]  roll;
      logic signed [qte_pkg::PITCHW-1:0] pitch;
      logic signed [qte_pkg::ROLLW-1:0]  yaw;
   } euler_type;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint UNIT_Q56    = 64'sd1 <<< 56;

   euler_type angles_q[$];

   longint atan_steps[32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007,
      64'h00000003, 64'h00000001, 64'h00000000, 64'h00000000};

   function automatic longint vector_angle(longint yv, longint xv);
      longint ang, t, dx, dy;
      ang = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         t = xv;
         if (yv >= 0) begin
            xv = yv; yv = -t; ang = HALF_PI_Q30;
         end else begin
            xv = -yv; yv = t; ang = -HALF_PI_Q30;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv >= 0) begin
            xv += dx; yv -= dy; ang += atan_steps[i];
         end else begin
            xv -= dx; yv += dy; ang -= atan_steps[i];
         end
      end
      return ang;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic longint hundredths(longint ang, longint lim);
      longint v;
      v = (ang * 64'sd5730 + (64'sd1 <<< 29)) >>> 30;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic euler_type euler_from_quat(longint w, longint x, longint y, longint z);
      longint ww, xx, yy, zz, wx, wy, wz, xy, xz, yz, s, s30, c30;
      euler_type e;
      ww = (w * w) >>> 4; xx = (x * x) >>> 4;
      yy = (y * y) >>> 4; zz = (z * z) >>> 4;
      wx = (w * x) >>> 4; wy = (w * y) >>> 4; wz = (w * z) >>> 4;
      xy = (x * y) >>> 4; xz = (x * z) >>> 4; yz = (y * z) >>> 4;
      s = 2 * (wy - xz);
      if (s > UNIT_Q56) s = UNIT_Q56;
      if (s < -UNIT_Q56) s = -UNIT_Q56;
      s30 = s >>> 26;
      c30 = longint'(int_sqrt((64'd1 << 60) - longint'(s30 * s30)));
      e.roll  = 16'(hundredths(vector_angle(2 * (yz + wx), UNIT_Q56 - 2 * xx - 2 * yy),
                               18002));
      e.pitch = 15'(hundredths(vector_angle(s30, c30), 9001));
      e.yaw   = 16'(hundredths(vector_angle(2 * (xy + wz), ww + xx - yy - zz), 18002));
      return e;
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      euler_type want;
      if (!reset) begin
         if (start && !busy)
            angles_q.push_back(euler_from_quat(req_quat_w, req_quat_x,
                                               req_quat_y, req_quat_z));
         if (rsp_valid) begin
            if (angles_q.size() == 0) begin
               // strobe with no transaction outstanding
               report("rsp_valid", 1, 0);
            end else begin
               want = angles_q.pop_front();
               if (rsp_roll_angle !== want.roll) report("roll", rsp_roll_angle, want.roll);
               if (rsp_pitch_angle !== want.pitch)
                  report("pitch", rsp_pitch_angle, want.pitch);
               if (rsp_yaw_angle !== want.yaw) report("yaw", rsp_yaw_angle, want.yaw);
            end
         end
      end
      angles_pending = angles_q.size();
   end
endmodule

// File: tb/quaternion_to_euler_angles_tb.sv
module quaternion_to_euler_angles_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS      = qte_pkg::CORDIC_STEPS_DEF;
   localparam int LATENCY    = STEPS + 39;
   localparam int CYCLE_CAP  = 400000;
   localparam int ONE        = 1073741824;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [31:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic rsp_valid;
   logic signed [15:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [14:0] rsp_pitch_angle;
   int fail_count, angles_pending;
   int cycles = 0;
   bit burst;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (.*);
   quaternion_to_euler_angles_chk #(.CORDIC_STEPS(STEPS)) chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("quaternion_to_euler_angles_tb NOT OK");
         $finish;
      end
   end

   task automatic send_quat(int w, int x, int y, int z);
      int gap;
      start <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      do @(posedge clock); while (busy);
      // alternate between back-to-back stretches and random gaps
      if ($urandom_range(0, 63) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic real unit_rand();
      return ($urandom / 4294967295.0) * 2.0 - 1.0;
   endfunction

   task automatic send_unit();
      real c[4];
      real n;
      int q[4];
      n = 0.0;
      foreach (c[i]) begin
         c[i] = unit_rand();
         n += c[i] * c[i];
      end
      n = $sqrt(n);
      if (n < 1.0e-3) n = 1.0;
      foreach (q[i]) q[i] = int'(c[i] * ONE / n);
      // perturb lsbs so rounding boundaries get hit
      if ($urandom_range(0, 3) == 0) foreach (q[i]) q[i] += $signed($urandom_range(0, 8)) - 4;
      send_quat(q[0], q[1], q[2], q[3]);
   endtask

   initial begin
      int h, k;
      h = 759250125;  // 2^30 / sqrt(2)
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_quat(0, 0, 0, 0);
      send_quat(ONE, 0, 0, 0);
      send_quat(-ONE, 0, 0, 0);
      send_quat(0, ONE, 0, 0);
      send_quat(0, 0, ONE, 0);
      send_quat(0, 0, 0, ONE);
      send_quat(0, -ONE, 0, 0);
      send_quat(0, 0, -ONE, 0);
      send_quat(0, 0, 0, -ONE);
      send_quat(h, 0, h, 0);           // pitch at +90
      send_quat(h, 0, -h, 0);          // pitch at -90
      send_quat(ONE, 0, ONE, 0);       // sine beyond one
      send_quat(ONE, ONE, -ONE, ONE);  // sine below minus one
      send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_quat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_quat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_quat(0, h, h, 0);           // roll numerator zero
      send_quat(h, 0, 0, -h);          // yaw at -90
      send_quat(0, 0, h, h);
      send_quat(1, 0, 0, 0);
      for (int i = 0; i < 1800; i++) begin
         k = $urandom_range(0, 9);
         if (k < 6) begin
            send_unit();
         end else if (k < 8) begin
            // near gimbal lock
            send_quat(h + $signed($urandom_range(0, 2000000)) - 1000000,
                      $signed($urandom_range(0, 2000)) - 1000,
                      ($urandom_range(0, 1) ? h : -h) + $signed($urandom_range(0, 2000)) - 1000,
                      $signed($urandom_range(0, 2000)) - 1000);
         end else begin
            send_quat($urandom, $urandom, $urandom, $urandom);
         end
      end
      start <= 0;
      while (angles_pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("quaternion_to_euler_angles_tb OK");
      end else begin
         $display("quaternion_to_euler_angles_tb NOT OK");
      end
      $finish;
   end
endmodule

// File: quaternion_to_euler_angles.f
sv/qte_pkg.sv
sv/qte_front.sv
sv/qte_queue.sv
sv/qte_isqrt.sv
sv/qte_cordic.sv
sv/qte_back.sv
sv/quaternion_to_euler_angles.sv
tb/quaternion_to_euler_angles_chk.sv
tb/quaternion_to_euler_angles_tb.sv
